FILE: sv/rhtg_pkg.sv
// Shared types, constants and helper functions of the random heading trajectory generator.
// No dependencies; every other file of the block imports this package.
package rhtg_pkg;

	localparam int TRIG_ITERATIONS = 20;

	localparam logic signed [25:0] PI_Q = 26'sd3294199;
	localparam logic signed [25:0] HALF_PI_Q = 26'sd1647099;
	localparam logic signed [25:0] TWO_PI_Q = 26'sd6588398;
	localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

	localparam logic [2:0] CFG_SPEED = 3'd0;
	localparam logic [2:0] CFG_TIME_STEP = 3'd1;
	localparam logic [2:0] CFG_GAIN = 3'd2;
	localparam logic [2:0] CFG_RETARGET = 3'd3;
	localparam logic [2:0] CFG_PITCH_LIMIT = 3'd4;

	localparam logic [4:0] OP_NOP = 5'd0;
	localparam logic [4:0] OP_CAPTURE = 5'd1;
	localparam logic [4:0] OP_RETARGET = 5'd2;
	localparam logic [4:0] OP_MUL_YR = 5'd3;
	localparam logic [4:0] OP_ACC_YR = 5'd4;
	localparam logic [4:0] OP_MUL_PR = 5'd5;
	localparam logic [4:0] OP_ACC_PR = 5'd6;
	localparam logic [4:0] OP_MUL_YA = 5'd7;
	localparam logic [4:0] OP_ACC_YA = 5'd8;
	localparam logic [4:0] OP_WRAP_A = 5'd9;
	localparam logic [4:0] OP_WRAP_B = 5'd10;
	localparam logic [4:0] OP_WRAP_C = 5'd11;
	localparam logic [4:0] OP_MUL_PA = 5'd12;
	localparam logic [4:0] OP_ACC_PA = 5'd13;
	localparam logic [4:0] OP_LOAD_Y = 5'd14;
	localparam logic [4:0] OP_LOAD_P = 5'd15;
	localparam logic [4:0] OP_RED = 5'd16;
	localparam logic [4:0] OP_FOLD = 5'd17;
	localparam logic [4:0] OP_HALF = 5'd18;
	localparam logic [4:0] OP_CORD = 5'd19;
	localparam logic [4:0] OP_STORE = 5'd20;
	localparam logic [4:0] OP_MUL_ST = 5'd21;
	localparam logic [4:0] OP_STEP = 5'd22;
	localparam logic [4:0] OP_MUL_HOR = 5'd23;
	localparam logic [4:0] OP_HOR = 5'd24;
	localparam logic [4:0] OP_MUL_DX = 5'd25;
	localparam logic [4:0] OP_POS_X = 5'd26;
	localparam logic [4:0] OP_MUL_DY = 5'd27;
	localparam logic [4:0] OP_POS_Y = 5'd28;
	localparam logic [4:0] OP_MUL_DZ = 5'd29;
	localparam logic [4:0] OP_POS_Z = 5'd30;
	localparam logic [4:0] OP_OUT = 5'd31;

	localparam logic [1:0] PH_YAW = 2'd0;
	localparam logic [1:0] PH_PITCH = 2'd1;
	localparam logic [1:0] PH_HALF = 2'd2;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] phase;
	} cmd_t;

	typedef struct packed {
		logic cordic_last;
		logic out_busy;
	} sts_t;

	function automatic logic signed [33:0] atan_val(input logic [4:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0: r = 34'sd843314857;
			5'd1: r = 34'sd497837829;
			5'd2: r = 34'sd263043837;
			5'd3: r = 34'sd133525159;
			5'd4: r = 34'sd67021687;
			5'd5: r = 34'sd33543516;
			5'd6: r = 34'sd16775851;
			5'd7: r = 34'sd8388437;
			5'd8: r = 34'sd4194283;
			5'd9: r = 34'sd2097149;
			5'd10: r = 34'sd1048576;
			5'd11: r = 34'sd524288;
			5'd12: r = 34'sd262144;
			5'd13: r = 34'sd131072;
			5'd14: r = 34'sd65536;
			5'd15: r = 34'sd32768;
			5'd16: r = 34'sd16384;
			5'd17: r = 34'sd8192;
			5'd18: r = 34'sd4096;
			5'd19: r = 34'sd2048;
			5'd20: r = 34'sd1024;
			5'd21: r = 34'sd512;
			5'd22: r = 34'sd256;
			5'd23: r = 34'sd128;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
		logic signed [23:0] r;
		if (v > 40'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -40'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -40'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] quat_of(input logic signed [33:0] v);
		logic signed [33:0] r;
		logic signed [15:0] q;
		r = (v + 34'sd32768) >>> 16;
		if (r > 34'sd16384) begin
			q = 16'sd16384;
		end else if (r < -34'sd16384) begin
			q = -16'sd16384;
		end else begin
			q = r[15:0];
		end
		return q;
	endfunction

endpackage

FILE: sv/rhtg_datapath.sv
// Datapath: configuration registers, state, shared multiplier, shared CORDIC and output register.
// Depends on rhtg_pkg; driven by commands from rhtg_controller.
module rhtg_datapath (
	input logic clk,
	input logic arst_n,
	input rhtg_pkg::cmd_t cmd,
	output rhtg_pkg::sts_t sts,
	input logic cfg_valid,
	input logic [2:0] cfg_index,
	input logic [23:0] cfg_data,
	input logic signed [20:0] draw_yaw_rate,
	input logic signed [20:0] draw_pitch_rate,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [22:0] heading_yaw,
	output logic signed [23:0] heading_pitch,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w
);
	import rhtg_pkg::*;

	logic [23:0] speed_q;
	logic [15:0] time_step_q;
	logic [15:0] gain_q;
	logic [15:0] ticks_q;
	logic [20:0] limit_q;

	logic signed [20:0] dyr_q, dpr_q;
	logic [15:0] cnt_q;
	logic signed [23:0] tyr_q, tpr_q, yr_q, pr_q, pitch_q;
	logic signed [25:0] yaw_q, arg_q;
	logic signed [31:0] pos_q [3];
	logic signed [65:0] prod_q;
	logic neg_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [4:0] it_q;
	logic signed [33:0] cyaw_q, syaw_q, cpit_q, spit_q, ch_q, sh_q;
	logic signed [24:0] step_q;
	logic signed [33:0] hor_q;
	logic out_valid_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] r16_full, r30_full;
	logic signed [39:0] r16, r30;
	logic [16:0] cnt_p1;
	logic signed [24:0] lim_s, pitch_s;
	logic signed [25:0] fold_a;
	logic fold_neg;
	logic signed [33:0] cdx, cdy, cat;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_YR: begin
				mul_a = {17'd0, gain_q};
				mul_b = 33'(tyr_q) - 33'(yr_q);
			end
			OP_MUL_PR: begin
				mul_a = {17'd0, gain_q};
				mul_b = 33'(tpr_q) - 33'(pr_q);
			end
			OP_MUL_YA: begin
				mul_a = 33'(yr_q);
				mul_b = {17'd0, time_step_q};
			end
			OP_MUL_PA: begin
				mul_a = 33'(pr_q);
				mul_b = {17'd0, time_step_q};
			end
			OP_MUL_ST: begin
				mul_a = {9'd0, speed_q};
				mul_b = {17'd0, time_step_q};
			end
			OP_MUL_HOR: begin
				mul_a = 33'(step_q);
				mul_b = cpit_q[32:0];
			end
			OP_MUL_DX: begin
				mul_a = hor_q[32:0];
				mul_b = cyaw_q[32:0];
			end
			OP_MUL_DY: begin
				mul_a = hor_q[32:0];
				mul_b = syaw_q[32:0];
			end
			OP_MUL_DZ: begin
				mul_a = 33'(step_q);
				mul_b = spit_q[32:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign r16_full = (prod_q + 66'sd32768) >>> 16;
	assign r30_full = (prod_q + 66'sd536870912) >>> 30;
	assign r16 = r16_full[39:0];
	assign r30 = r30_full[39:0];
	assign cnt_p1 = {1'b0, cnt_q} + 17'd1;
	assign lim_s = {4'd0, limit_q};
	assign pitch_s = 25'(pitch_q);

	always_comb begin
		fold_a = arg_q;
		fold_neg = 1'b0;
		if (arg_q > HALF_PI_Q) begin
			fold_a = arg_q - PI_Q;
			fold_neg = 1'b1;
		end else if (arg_q < -HALF_PI_Q) begin
			fold_a = arg_q + PI_Q;
			fold_neg = 1'b1;
		end
	end

	assign cdx = cy_q >>> it_q;
	assign cdy = cx_q >>> it_q;
	assign cat = atan_val(it_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 24'd327680;
			time_step_q <= 16'd1311;
			gain_q <= 16'd1311;
			ticks_q <= 16'd50;
			limit_q <= 21'd1098066;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SPEED: speed_q <= cfg_data;
				CFG_TIME_STEP: time_step_q <= cfg_data[15:0];
				CFG_GAIN: gain_q <= cfg_data[15:0];
				CFG_RETARGET: ticks_q <= cfg_data[15:0];
				CFG_PITCH_LIMIT: limit_q <= cfg_data[20:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			tyr_q <= 24'sd524288;
			tpr_q <= 24'sd314573;
			yr_q <= '0;
			pr_q <= '0;
			yaw_q <= PI_Q;
			pitch_q <= 24'sd104858;
			pos_q[0] <= 32'sd655360;
			pos_q[1] <= 32'sd655360;
			pos_q[2] <= 32'sd655360;
			it_q <= '0;
		end else begin
			case (cmd.op)
				OP_RETARGET: begin
					if (cnt_p1 >= {1'b0, ticks_q}) begin
						cnt_q <= '0;
						tyr_q <= 24'(dyr_q);
						tpr_q <= 24'(dpr_q) >>> 1;
					end else begin
						cnt_q <= cnt_p1[15:0];
					end
				end
				OP_ACC_YR: yr_q <= sat24(40'(yr_q) + r16);
				OP_ACC_PR: begin
					pr_q <= sat24(40'(pr_q) + r16);
					if (pitch_s > lim_s) begin
						pitch_q <= lim_s[23:0];
					end else if (pitch_s < -lim_s) begin
						pitch_q <= 24'(-lim_s);
					end
				end
				OP_ACC_YA: yaw_q <= yaw_q + r16[25:0];
				OP_WRAP_A, OP_WRAP_B, OP_WRAP_C: begin
					if (yaw_q > PI_Q) begin
						yaw_q <= yaw_q - TWO_PI_Q;
					end else if (yaw_q <= -PI_Q) begin
						yaw_q <= yaw_q + TWO_PI_Q;
					end
				end
				OP_ACC_PA: pitch_q <= sat24(40'(pitch_q) + r16);
				OP_FOLD, OP_HALF: it_q <= '0;
				OP_CORD: it_q <= it_q + 5'd1;
				OP_POS_X: pos_q[0] <= sat32(40'(pos_q[0]) + r30);
				OP_POS_Y: pos_q[1] <= sat32(40'(pos_q[1]) + r30);
				OP_POS_Z: pos_q[2] <= sat32(40'(pos_q[2]) + r30);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				dyr_q <= draw_yaw_rate;
				dpr_q <= draw_pitch_rate;
			end
			OP_MUL_YR, OP_MUL_PR, OP_MUL_YA, OP_MUL_PA, OP_MUL_ST, OP_MUL_HOR,
			OP_MUL_DX, OP_MUL_DY, OP_MUL_DZ: prod_q <= mul_a * mul_b;
			OP_LOAD_Y: arg_q <= yaw_q;
			OP_LOAD_P: arg_q <= 26'(pitch_q);
			OP_RED: begin
				if (arg_q > PI_Q) begin
					arg_q <= arg_q - TWO_PI_Q;
				end else if (arg_q <= -PI_Q) begin
					arg_q <= arg_q + TWO_PI_Q;
				end
			end
			OP_FOLD: begin
				neg_q <= fold_neg;
				cx_q <= CORDIC_K;
				cy_q <= '0;
				cz_q <= 34'(fold_a) <<< 10;
			end
			OP_HALF: begin
				neg_q <= 1'b0;
				cx_q <= CORDIC_K;
				cy_q <= '0;
				cz_q <= 34'(yaw_q) <<< 9;
			end
			OP_CORD: begin
				if (cz_q >= 0) begin
					cx_q <= cx_q - cdx;
					cy_q <= cy_q + cdy;
					cz_q <= cz_q - cat;
				end else begin
					cx_q <= cx_q + cdx;
					cy_q <= cy_q - cdy;
					cz_q <= cz_q + cat;
				end
			end
			OP_STORE: begin
				case (cmd.phase)
					PH_YAW: begin
						cyaw_q <= neg_q ? -cx_q : cx_q;
						syaw_q <= neg_q ? -cy_q : cy_q;
					end
					PH_PITCH: begin
						cpit_q <= neg_q ? -cx_q : cx_q;
						spit_q <= neg_q ? -cy_q : cy_q;
					end
					default: begin
						ch_q <= cx_q;
						sh_q <= cy_q;
					end
				endcase
			end
			OP_STEP: step_q <= r16[24:0];
			OP_HOR: hor_q <= r30[33:0];
			OP_OUT: begin
				pos_x <= pos_q[0];
				pos_y <= pos_q[1];
				pos_z <= pos_q[2];
				heading_yaw <= yaw_q[22:0];
				heading_pitch <= pitch_q;
				quat_z <= quat_of(sh_q);
				quat_w <= quat_of(ch_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign sts.cordic_last = (it_q == 5'(TRIG_ITERATIONS - 1));
	assign sts.out_busy = out_valid_q && !out_ready;

	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |=> out_valid_q)
		else $error("Output register not valid after a load.");

	a_yaw_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_MUL_PA |-> (yaw_q <= PI_Q && yaw_q > -PI_Q))
		else $error("Yaw left its range after wrapping.");

	a_cordic_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_CORD |-> it_q < 5'(TRIG_ITERATIONS))
		else $error("CORDIC ran past its iteration count.");

endmodule

FILE: sv/rhtg_controller.sv
// Sequencer that steps the datapath through one tick of the trajectory update.
// Depends on rhtg_pkg; drives rhtg_datapath through cmd_t and reads sts_t.
module rhtg_controller (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input rhtg_pkg::sts_t sts,
	output rhtg_pkg::cmd_t cmd
);
	import rhtg_pkg::*;

	logic [4:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		case (state_q)
			OP_NOP: if (in_valid) state_d = OP_RETARGET;
			OP_RETARGET: state_d = OP_MUL_YR;
			OP_MUL_YR: state_d = OP_ACC_YR;
			OP_ACC_YR: state_d = OP_MUL_PR;
			OP_MUL_PR: state_d = OP_ACC_PR;
			OP_ACC_PR: state_d = OP_MUL_YA;
			OP_MUL_YA: state_d = OP_ACC_YA;
			OP_ACC_YA: state_d = OP_WRAP_A;
			OP_WRAP_A: state_d = OP_WRAP_B;
			OP_WRAP_B: state_d = OP_WRAP_C;
			OP_WRAP_C: state_d = OP_MUL_PA;
			OP_MUL_PA: state_d = OP_ACC_PA;
			OP_ACC_PA: begin
				state_d = OP_LOAD_Y;
				phase_d = PH_YAW;
			end
			OP_LOAD_Y: state_d = OP_RED;
			OP_LOAD_P: state_d = OP_RED;
			OP_RED: state_d = OP_FOLD;
			OP_FOLD: state_d = OP_CORD;
			OP_HALF: state_d = OP_CORD;
			OP_CORD: if (sts.cordic_last) state_d = OP_STORE;
			OP_STORE: begin
				case (phase_q)
					PH_YAW: begin
						state_d = OP_LOAD_P;
						phase_d = PH_PITCH;
					end
					PH_PITCH: begin
						state_d = OP_HALF;
						phase_d = PH_HALF;
					end
					default: state_d = OP_MUL_ST;
				endcase
			end
			OP_MUL_ST: state_d = OP_STEP;
			OP_STEP: state_d = OP_MUL_HOR;
			OP_MUL_HOR: state_d = OP_HOR;
			OP_HOR: state_d = OP_MUL_DX;
			OP_MUL_DX: state_d = OP_POS_X;
			OP_POS_X: state_d = OP_MUL_DY;
			OP_MUL_DY: state_d = OP_POS_Y;
			OP_POS_Y: state_d = OP_MUL_DZ;
			OP_MUL_DZ: state_d = OP_POS_Z;
			OP_POS_Z: state_d = OP_OUT;
			OP_OUT: if (!sts.out_busy) state_d = OP_NOP;
			default: state_d = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OP_NOP;
			phase_q <= PH_YAW;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		cmd.phase = phase_q;
		cmd.op = state_q;
		if (state_q == OP_NOP) begin
			cmd.op = in_valid ? OP_CAPTURE : OP_NOP;
		end else if (state_q == OP_OUT && sts.out_busy) begin
			cmd.op = OP_NOP;
		end
	end

	assign in_ready = (state_q == OP_NOP);

endmodule

FILE: sv/random_heading_trajectory_generator_top.sv
// Top level of the random heading trajectory generator: sequencer plus datapath.
// Depends on rhtg_pkg, rhtg_controller and rhtg_datapath.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   draw_yaw_rate, draw_pitch_rate
//   out      out_valid / out_ready pos_x..z, heading_yaw, heading_pitch, quat_z, quat_w
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each tick runs three passes of the single shared CORDIC unit plus the shared
// multiplier steps.
// One tick is in flight at a time; the next beat is taken once the result is loaded.
// A result stalled at the output holds the sequencer in its final step.
// Reset restores the documented state and register defaults; cfg_ready is always high.
module random_heading_trajectory_generator_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [20:0] draw_yaw_rate,
	input logic signed [20:0] draw_pitch_rate,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [22:0] heading_yaw,
	output logic signed [23:0] heading_pitch,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [23:0] cfg_data
);
	import rhtg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	rhtg_controller u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	rhtg_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.draw_yaw_rate(draw_yaw_rate),
		.draw_pitch_rate(draw_pitch_rate),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.heading_yaw(heading_yaw),
		.heading_pitch(heading_pitch),
		.quat_z(quat_z),
		.quat_w(quat_w)
	);

endmodule
